### rtl/core/ugim_pkg.sv
// ----------------------------------------------------------------------------
// ugim_pkg
// Shared types and constants of the utf-8 glyph index mapper.
// ----------------------------------------------------------------------------
package ugim_pkg;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned GLYPH_W = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  // utf-8 lead byte decode
  localparam logic [2:0]        LEAD2_TAG   = 3'b110;
  localparam logic [3:0]        LEAD3_TAG   = 4'b1110;
  localparam logic [CODE_W-1:0] SPACE_CODE  = 16'h0020;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  // register index of map_count
  localparam logic REG_MAP_COUNT = 1'b0;

  // transfer moving along the cell chain
  typedef struct packed {
    logic               is_load;
    logic               hit;
    logic [CODE_W-1:0]  code;
    logic [GLYPH_W-1:0] glyph;
  } tok_t;

endpackage

### rtl/core/utf8_glyph_index_mapper_core.sv
// ----------------------------------------------------------------------------
// utf8_glyph_index_mapper_core
// Utf-8 decoder with a code point to glyph index table held in a cell chain.
// ----------------------------------------------------------------------------
// Command-style block: an item is taken when start is high and busy is low.
// A text byte that completes a character starts a table walk and its result
// appears on done_o as a one-cycle strobe once it has passed the issue register and
// the row of MAP_DEPTH cells; the receiver cannot stall it, so it must take
// every result as it comes. A load item also walks the chain, with busy high
// until it leaves, and gives no result. A text byte that ends no character,
// or a load to a slot at or above MAP_DEPTH, leaves busy low. map_count is
// set through the apb-style port at byte address 0; the user must set it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module utf8_glyph_index_mapper_core #(
  parameter int unsigned MAP_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           command_i,
  input  logic [ugim_pkg::SLOT_W-1:0]    slot_i,
  input  logic [ugim_pkg::CODE_W-1:0]    entry_code_i,
  input  logic [ugim_pkg::GLYPH_W-1:0]   entry_glyph_i,
  input  logic [ugim_pkg::BYTE_W-1:0]    text_byte_i,
  // result strobe
  output logic                           done_o,
  output logic [ugim_pkg::CODE_W-1:0]    code_point_o,
  output logic [ugim_pkg::GLYPH_W-1:0]   glyph_number_o,
  output logic                           found_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // countdown width must hold MAP_DEPTH itself
  localparam int unsigned CNT_W = $clog2(MAP_DEPTH + 1);

  // ---------------------------------------------------------------- config
  logic [ugim_pkg::COUNT_W-1:0] map_count_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ugim_pkg::REG_MAP_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_count_q <= '0;
    end else if (cfg_wr) begin
      map_count_q <= pwdata[ugim_pkg::COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ugim_pkg::REG_MAP_COUNT) ?
                  {{(32-ugim_pkg::COUNT_W){1'b0}}, map_count_q} : 32'd0;

  // ---------------------------------------------------------------- accept
  logic accept;
  logic text_en;
  logic dec_emit;
  logic [ugim_pkg::CODE_W-1:0] dec_code;
  logic [CNT_W-1:0] limit;
  logic slot_ok;

  assign accept  = start && !busy;
  assign text_en = accept && (command_i == ugim_pkg::CMD_TEXT);

  ugim_utf8_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (text_en),
    .byte_i (text_byte_i),
    .emit_o (dec_emit),
    .code_o (dec_code)
  );

  // search no more slots than the chain holds
  assign limit   = (32'(map_count_q) > MAP_DEPTH) ? CNT_W'(MAP_DEPTH)
                                                  : CNT_W'(map_count_q);
  // loads beyond the table are dropped
  assign slot_ok = (32'(slot_i) < MAP_DEPTH);

  // ---------------------------------------------------------------- issue
  logic            issue_vld_q, issue_vld_d;
  ugim_pkg::tok_t  issue_tok_q, issue_tok_d;
  logic [CNT_W-1:0] issue_cnt_q, issue_cnt_d;
  logic            busy_q, busy_d;

  logic            chain_vld [MAP_DEPTH+1];
  ugim_pkg::tok_t  chain_tok [MAP_DEPTH+1];
  logic [CNT_W-1:0] chain_cnt [MAP_DEPTH+1];
  logic            chain_exit;

  assign chain_exit = chain_vld[MAP_DEPTH];

  always_comb begin
    issue_vld_d = 1'b0;
    issue_tok_d = issue_tok_q;
    issue_cnt_d = issue_cnt_q;
    busy_d      = busy_q;
    if (chain_exit) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      if (command_i == ugim_pkg::CMD_TEXT) begin
        if (dec_emit) begin
          issue_vld_d         = 1'b1;
          issue_tok_d.is_load = 1'b0;
          issue_tok_d.hit     = 1'b0;
          issue_tok_d.code    = dec_code;
          issue_tok_d.glyph   = '0;
          issue_cnt_d         = limit;
          busy_d              = 1'b1;
        end
      end else if (slot_ok) begin
        issue_vld_d         = 1'b1;
        issue_tok_d.is_load = 1'b1;
        issue_tok_d.hit     = 1'b0;
        issue_tok_d.code    = entry_code_i;
        issue_tok_d.glyph   = entry_glyph_i;
        issue_cnt_d         = CNT_W'(slot_i);
        busy_d              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_vld_q <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      issue_vld_q <= issue_vld_d;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_tok_q <= issue_tok_d;
    issue_cnt_q <= issue_cnt_d;
  end

  assign busy = busy_q;

  // ---------------------------------------------------------------- chain
  assign chain_vld[0] = issue_vld_q;
  assign chain_tok[0] = issue_tok_q;
  assign chain_cnt[0] = issue_cnt_q;

  // one table slot per cell, transfer moves one cell per cycle
  for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_cell
    ugim_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (chain_vld[g]),
      .tok_i  (chain_tok[g]),
      .cnt_i  (chain_cnt[g]),
      .vld_o  (chain_vld[g+1]),
      .tok_o  (chain_tok[g+1]),
      .cnt_o  (chain_cnt[g+1])
    );
  end

  // ---------------------------------------------------------------- result
  // last cell output is registered, so results leave straight from it
  assign done_o         = chain_exit && !chain_tok[MAP_DEPTH].is_load;
  assign code_point_o   = chain_tok[MAP_DEPTH].code;
  assign glyph_number_o = chain_tok[MAP_DEPTH].glyph;
  assign found_o        = chain_tok[MAP_DEPTH].hit;

  // ---------------------------------------------------------------- checks
  // a transfer leaving the chain always belongs to a busy walk
  assert property (@(posedge clk_i) disable iff (!rst_ni) chain_exit |-> busy_q)
    else $error("chain exit while not busy");

  // the walk ends when its transfer leaves the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni) chain_exit |=> !busy_q)
    else $error("busy held after walk end");

  // a miss reports glyph zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && !found_o) |-> (glyph_number_o == '0))
    else $error("miss with non-zero glyph");

  // a transfer enters the chain only on a newly started walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   issue_vld_q |-> (busy_q && !$past(busy_q)))
    else $error("issue outside walk start");

endmodule

### rtl/core/ugim_utf8_dec.sv
// ----------------------------------------------------------------------------
// ugim_utf8_dec
// Utf-8 byte decoder holding the partial code point and bytes still due.
// ----------------------------------------------------------------------------
module ugim_utf8_dec (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [ugim_pkg::BYTE_W-1:0]   byte_i,
  output logic                          emit_o,
  output logic [ugim_pkg::CODE_W-1:0]   code_o
);

  logic [1:0]                    bytes_left_q, bytes_left_d;
  logic [ugim_pkg::CODE_W-1:0]   partial_q, partial_d;
  logic [ugim_pkg::CODE_W-1:0]   cont_code;

  assign cont_code = {partial_q[ugim_pkg::CODE_W-7:0], byte_i[5:0]};

  always_comb begin
    bytes_left_d = bytes_left_q;
    partial_d    = partial_q;
    emit_o       = 1'b0;
    code_o       = ugim_pkg::SPACE_CODE;
    if (bytes_left_q != 2'd0) begin
      // continuation taken unchecked, low six bits only
      partial_d    = cont_code;
      bytes_left_d = bytes_left_q - 2'd1;
      emit_o       = (bytes_left_q == 2'd1);
      code_o       = cont_code;
    end else if (!byte_i[7]) begin
      emit_o = 1'b1;
      code_o = {{(ugim_pkg::CODE_W-ugim_pkg::BYTE_W){1'b0}}, byte_i};
    end else if (byte_i[7:5] == ugim_pkg::LEAD2_TAG) begin
      partial_d    = {{(ugim_pkg::CODE_W-5){1'b0}}, byte_i[4:0]};
      bytes_left_d = 2'd1;
    end else if (byte_i[7:4] == ugim_pkg::LEAD3_TAG) begin
      partial_d    = {{(ugim_pkg::CODE_W-4){1'b0}}, byte_i[3:0]};
      bytes_left_d = 2'd2;
    end else begin
      emit_o = 1'b1;
      code_o = ugim_pkg::SPACE_CODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 2'd0;
      partial_q    <= '0;
    end else if (en_i) begin
      bytes_left_q <= bytes_left_d;
      partial_q    <= partial_d;
    end
  end

endmodule

### rtl/core/ugim_cell.sv
// ----------------------------------------------------------------------------
// ugim_cell
// One table slot of the lookup chain; compares or writes a passing transfer.
// ----------------------------------------------------------------------------
module ugim_cell #(
  parameter int unsigned CNT_W = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  ugim_pkg::tok_t       tok_i,
  input  logic [CNT_W-1:0]     cnt_i,
  output logic                 vld_o,
  output ugim_pkg::tok_t       tok_o,
  output logic [CNT_W-1:0]     cnt_o
);

  logic                           vld_q;
  ugim_pkg::tok_t                 tok_q, tok_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [ugim_pkg::CODE_W-1:0]    entry_code_q;
  logic [ugim_pkg::GLYPH_W-1:0]   entry_glyph_q;
  logic                           cnt_zero;
  logic                           wr_en;

  assign cnt_zero = (cnt_i == '0);
  // load lands in the slot where its countdown hits zero
  assign wr_en    = vld_i && tok_i.is_load && cnt_zero && !tok_i.hit;

  always_comb begin
    tok_d = tok_i;
    cnt_d = cnt_zero ? cnt_i : cnt_i - CNT_W'(1);
    if (tok_i.is_load) begin
      if (cnt_zero) begin
        tok_d.hit = 1'b1;
      end
    end else if (!cnt_zero && !tok_i.hit && (tok_i.code == entry_code_q)) begin
      tok_d.hit   = 1'b1;
      tok_d.glyph = entry_glyph_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    cnt_q <= cnt_d;
    if (wr_en) begin
      entry_code_q  <= tok_i.code;
      entry_glyph_q <= tok_i.glyph;
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule
